[rtl/gfr_pkg.sv]
// gfr_pkg: shared types and constants of the grid frequency and rms meter
// depends on nothing; used by the interfaces and every rtl module
package gfr_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO_LEVEL     = 3'd0,
		REG_SAMPLE_ALPHA   = 3'd1,
		REG_SAMPLE_GAIN    = 3'd2,
		REG_SAMPLE_RATE    = 3'd3,
		REG_FREQ_ALPHA     = 3'd4,
		REG_LOW_LIMIT      = 3'd5,
		REG_HIGH_LIMIT     = 3'd6,
		REG_RMS_SCALE      = 3'd7
	} cfg_reg_t;

	// register reset values
	localparam logic [9:0]  ZERO_LEVEL_RST   = 10'd511;
	localparam logic [15:0] SAMPLE_ALPHA_RST = 16'd1996;
	localparam logic [12:0] SAMPLE_GAIN_RST  = 13'd4321;
	localparam logic [15:0] SAMPLE_RATE_RST  = 16'd9975;
	localparam logic [15:0] FREQ_ALPHA_RST   = 16'd1996;
	localparam logic [23:0] LOW_LIMIT_RST    = 24'd49900;
	localparam logic [23:0] HIGH_LIMIT_RST   = 24'd50100;
	localparam logic [15:0] RMS_SCALE_RST    = 16'd16446;
	localparam logic [23:0] FREQ_RST         = 24'd50000;

	// band status codes
	typedef enum logic [1:0] {
		BAND_WITHIN = 2'd0,
		BAND_BELOW  = 2'd1,
		BAND_ABOVE  = 2'd2
	} band_t;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 29;
	localparam int MUL_B_W = 26;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// shared divider
	localparam int DIV_W    = 56;
	localparam int DEN_W    = 24;
	localparam int STEP_W   = 6;
	localparam int FRAC_STEPS = 24;
	localparam int FREQ_STEPS = 35;
	localparam int RMS_STEPS  = 56;

	// square root
	localparam int ROOT_W = DIV_W / 2;

	localparam logic [23:0] MAX24 = 24'hFFFFFF;

	typedef struct packed {
		logic                start;
		logic [DIV_W-1:0]    num;
		logic [DEN_W-1:0]    den;
		logic [STEP_W-1:0]   steps;
	} div_req_t;

endpackage

[rtl/gfr_if.sv]
// gfr_if: valid/ready channels of the meter (sample in, result out, config)
// depends on gfr_pkg
interface gfr_sample_if #(parameter int SAMPLE_BITS = 10);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface gfr_result_if;
	logic        valid;
	logic        ready;
	logic [23:0] period_q8;
	logic [23:0] frequency_mhz;
	logic [15:0] rms_centivolts;
	logic [1:0]  band_status;
	logic        drive_clockwise;
	logic        drive_counter_clockwise;
	modport source (output valid, output period_q8, output frequency_mhz,
		output rms_centivolts, output band_status, output drive_clockwise,
		output drive_counter_clockwise, input ready);
	modport sink (input valid, input period_q8, input frequency_mhz,
		input rms_centivolts, input band_status, input drive_clockwise,
		input drive_counter_clockwise, output ready);
endinterface

interface gfr_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [gfr_pkg::CFG_IDX_W-1:0]   index;
	logic [gfr_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/grid_frequency_rms_meter.sv]
// grid_frequency_rms_meter: top level, holds the sequencer, config registers and
// result register; uses gfr_pkg, gfr_if, gfr_mul, gfr_div and gfr_isqrt. Each sample
// beat is filtered, gain-scaled, squared and summed through one shared multiplier,
// so smp.ready is low while the blend, gain, diff, square and accumulate states
// run. A rising zero crossing of the filtered value adds the result
// computation: a 24-step fraction division, a 35-step frequency division, a 56-step
// division of the square sum by the period and a 28-step square root, all
// bit-serial, before the next sample beat can be taken. The result sits in an
// output register; a crossing waits only if the previous result beat has not
// been taken yet.
module grid_frequency_rms_meter #(
	parameter int SAMPLE_BITS = 10,
	parameter int COUNT_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	gfr_sample_if.sink    smp,
	gfr_result_if.source  res,
	gfr_cfg_if.sink       cfg
);

	localparam int CW = 17;
	localparam int SD = SAMPLE_BITS + 1;

	typedef enum logic [15:0] {
		ST_IDLE    = 16'h0001,
		ST_BLEND   = 16'h0002,
		ST_GAIN    = 16'h0004,
		ST_DIFF    = 16'h0008,
		ST_SQR     = 16'h0010,
		ST_ACC     = 16'h0020,
		ST_FRAC_W  = 16'h0040,
		ST_FREQ_GO = 16'h0080,
		ST_FREQ_W  = 16'h0100,
		ST_FB      = 16'h0200,
		ST_FB_W    = 16'h0400,
		ST_RMS_W   = 16'h0800,
		ST_SQRT_W  = 16'h1000,
		ST_RMS_MUL = 16'h2000,
		ST_CV      = 16'h4000,
		ST_EMIT    = 16'h8000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [9:0]  zero_level_q;
	logic [15:0] sample_alpha_q;
	logic [12:0] sample_gain_q;
	logic [15:0] sample_rate_q;
	logic [15:0] freq_alpha_q;
	logic [23:0] low_limit_q;
	logic [23:0] high_limit_q;
	logic [15:0] rms_scale_q;

	// working state
	logic [SAMPLE_BITS-1:0] x_q;
	logic [SAMPLE_BITS-1:0] filt_q;
	logic [SAMPLE_BITS-1:0] y_q;
	logic [16:0]            d_q;
	logic [31:0]            sum_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic [23:0]            period_q;
	logic [23:0]            raw_q;
	logic [23:0]            smooth_q;
	logic [15:0]            cv_q;

	// result register
	logic        res_valid_q;
	logic [23:0] res_period_q;
	logic [23:0] res_freq_q;
	logic [15:0] res_cv_q;
	logic [1:0]  res_band_q;

	// shared units
	logic signed [gfr_pkg::MUL_A_W-1:0] mul_a;
	logic signed [gfr_pkg::MUL_B_W-1:0] mul_b;
	logic signed [gfr_pkg::MUL_P_W-1:0] prod;
	gfr_pkg::div_req_t                  div_req;
	logic                               div_done;
	logic [gfr_pkg::DIV_W-1:0]          div_quo;
	logic                               sqrt_start;
	logic                               sqrt_done;
	logic [gfr_pkg::ROOT_W-1:0]         root;

	gfr_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

	gfr_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .done(div_done),
		.quo(div_quo));

	gfr_isqrt u_sqrt (.clk(clk), .arst_n(arst_n), .start(sqrt_start), .val(div_quo),
		.done(sqrt_done), .root(root));

	// combinational helpers
	logic [SD-1:0]                 dx;
	logic [gfr_pkg::MUL_P_W-1:0]   blend_sum;
	logic [SAMPLE_BITS:0]          g;
	logic [17:0]                   gz;
	logic [17:0]                   zz;
	logic [36:0]                   acc;
	logic [CW-1:0]                 y_c;
	logic [CW-1:0]                 prev_c;
	logic [CW-1:0]                 zero_c;
	logic                          crossing;
	logic [32:0]                   per_full;
	logic [24:0]                   dfreq;
	logic [34:0]                   freq_num;
	logic [gfr_pkg::MUL_P_W-1:0]   cv_full;
	logic                          out_free;
	logic                          cfg_hit;

	always_comb begin
		dx        = SD'(x_q) - SD'(filt_q);
		blend_sum = gfr_pkg::MUL_P_W'(prod >>> 16) + gfr_pkg::MUL_P_W'(filt_q);
		g         = prod[SAMPLE_BITS+12:12];
		gz        = 18'(g);
		zz        = 18'(zero_level_q);
		acc       = 37'(sum_q) + 37'(prod[35:0]);
		y_c       = CW'(y_q);
		prev_c    = CW'(filt_q);
		zero_c    = CW'(zero_level_q);
		crossing  = (prev_c < zero_c) && (y_c >= zero_c);
		per_full  = {1'b0, 32'({count_q, 8'h00})} - 33'(div_quo[7:0]);
		dfreq     = {1'b0, raw_q} - {1'b0, smooth_q};
		// rate * 256000 as rate * (2^18 - 2^12 - 2^11)
		freq_num  = 35'({sample_rate_q, 18'h00000}) - 35'({sample_rate_q, 12'h000})
			- 35'({sample_rate_q, 11'h000});
		cv_full   = gfr_pkg::MUL_P_W'(prod >>> 16);
		out_free  = !res_valid_q || res.ready;
		cfg_hit   = cfg.valid && cfg.ready;
	end

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_BLEND: begin
				mul_a = gfr_pkg::MUL_A_W'(sample_alpha_q);
				mul_b = {{(gfr_pkg::MUL_B_W-SD){dx[SD-1]}}, dx};
			end
			ST_GAIN: begin
				mul_a = gfr_pkg::MUL_A_W'(x_q);
				mul_b = gfr_pkg::MUL_B_W'(sample_gain_q);
			end
			ST_SQR: begin
				mul_a = gfr_pkg::MUL_A_W'(d_q);
				mul_b = gfr_pkg::MUL_B_W'(d_q);
			end
			ST_FB: begin
				mul_a = gfr_pkg::MUL_A_W'(freq_alpha_q);
				mul_b = {dfreq[24], dfreq};
			end
			ST_RMS_MUL: begin
				mul_a = gfr_pkg::MUL_A_W'(root);
				mul_b = gfr_pkg::MUL_B_W'(rms_scale_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// divider and root requests
	always_comb begin
		div_req       = '0;
		sqrt_start    = 1'b0;
		case (state_q)
			ST_ACC: begin
				div_req.start = crossing;
				div_req.num   = {16'(y_c - zero_c), 8'h00, 32'h0};
				div_req.den   = 24'(y_c - prev_c);
				div_req.steps = gfr_pkg::STEP_W'(gfr_pkg::FRAC_STEPS);
			end
			ST_FREQ_GO: begin
				div_req.start = 1'b1;
				div_req.num   = {freq_num, 21'h0};
				div_req.den   = period_q;
				div_req.steps = gfr_pkg::STEP_W'(gfr_pkg::FREQ_STEPS);
			end
			ST_FB_W: begin
				div_req.start = 1'b1;
				div_req.num   = {sum_q, 24'h0};
				div_req.den   = period_q;
				div_req.steps = gfr_pkg::STEP_W'(gfr_pkg::RMS_STEPS);
			end
			ST_RMS_W: begin
				sqrt_start = div_done;
			end
			default: begin
				div_req    = '0;
				sqrt_start = 1'b0;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_level_q   <= gfr_pkg::ZERO_LEVEL_RST;
			sample_alpha_q <= gfr_pkg::SAMPLE_ALPHA_RST;
			sample_gain_q  <= gfr_pkg::SAMPLE_GAIN_RST;
			sample_rate_q  <= gfr_pkg::SAMPLE_RATE_RST;
			freq_alpha_q   <= gfr_pkg::FREQ_ALPHA_RST;
			low_limit_q    <= gfr_pkg::LOW_LIMIT_RST;
			high_limit_q   <= gfr_pkg::HIGH_LIMIT_RST;
			rms_scale_q    <= gfr_pkg::RMS_SCALE_RST;
		end else if (cfg_hit) begin
			case (gfr_pkg::cfg_reg_t'(cfg.index))
				gfr_pkg::REG_ZERO_LEVEL:   zero_level_q   <= cfg.data[9:0];
				gfr_pkg::REG_SAMPLE_ALPHA: sample_alpha_q <= cfg.data[15:0];
				gfr_pkg::REG_SAMPLE_GAIN:  sample_gain_q  <= cfg.data[12:0];
				gfr_pkg::REG_SAMPLE_RATE:  sample_rate_q  <= cfg.data[15:0];
				gfr_pkg::REG_FREQ_ALPHA:   freq_alpha_q   <= cfg.data[15:0];
				gfr_pkg::REG_LOW_LIMIT:    low_limit_q    <= cfg.data;
				gfr_pkg::REG_HIGH_LIMIT:   high_limit_q   <= cfg.data;
				gfr_pkg::REG_RMS_SCALE:    rms_scale_q    <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// smoothing step for the frequency: prev + (alpha * diff) >>> 16
	function automatic logic [23:0] blend_sum_f(
		input logic signed [gfr_pkg::MUL_P_W-1:0] p,
		input logic [23:0]                         prev
	);
		logic [gfr_pkg::MUL_P_W-1:0] s;
		s = gfr_pkg::MUL_P_W'(p >>> 16) + gfr_pkg::MUL_P_W'(prev);
		return s[23:0];
	endfunction

	// sequencer and accumulated state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			filt_q      <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			smooth_q    <= gfr_pkg::FREQ_RST;
			res_valid_q <= 1'b0;
		end else begin
			// result beat: raised on emit, dropped once taken
			if (state_q == ST_EMIT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (smp.valid) begin
						state_q <= ST_BLEND;
					end
				end
				ST_BLEND: state_q <= ST_GAIN;
				ST_GAIN:  state_q <= ST_DIFF;
				ST_DIFF:  state_q <= ST_SQR;
				ST_SQR:   state_q <= ST_ACC;
				ST_ACC: begin
					filt_q <= y_q;
					sum_q  <= (acc[36:32] != 5'd0) ? 32'hFFFFFFFF : acc[31:0];
					if (count_q != {COUNT_BITS{1'b1}}) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= crossing ? ST_FRAC_W : ST_IDLE;
				end
				ST_FRAC_W: begin
					if (div_done) begin
						state_q <= ST_FREQ_GO;
					end
				end
				ST_FREQ_GO: state_q <= ST_FREQ_W;
				ST_FREQ_W: begin
					if (div_done) begin
						state_q <= ST_FB;
					end
				end
				ST_FB:   state_q <= ST_FB_W;
				ST_FB_W: begin
					smooth_q <= blend_sum_f(prod, smooth_q);
					state_q  <= ST_RMS_W;
				end
				ST_RMS_W: begin
					if (div_done) begin
						state_q <= ST_SQRT_W;
					end
				end
				ST_SQRT_W: begin
					if (sqrt_done) begin
						state_q <= ST_RMS_MUL;
					end
				end
				ST_RMS_MUL: state_q <= ST_CV;
				ST_CV:      state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						sum_q       <= '0;
						count_q     <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= smp.sample;
			end
			ST_GAIN: begin
				y_q <= blend_sum[SAMPLE_BITS-1:0];
			end
			ST_DIFF: begin
				d_q <= (gz >= zz) ? 17'(gz - zz) : 17'(zz - gz);
			end
			ST_FRAC_W: begin
				period_q <= (per_full > 33'(gfr_pkg::MAX24)) ? gfr_pkg::MAX24 : per_full[23:0];
			end
			ST_FREQ_W: begin
				raw_q <= (div_quo > gfr_pkg::DIV_W'(gfr_pkg::MAX24)) ? gfr_pkg::MAX24
					: div_quo[23:0];
			end
			ST_CV: begin
				cv_q <= (cv_full > gfr_pkg::MUL_P_W'(16'hFFFF)) ? 16'hFFFF : cv_full[15:0];
			end
			ST_EMIT: begin
				if (out_free) begin
					res_period_q <= period_q;
					res_freq_q   <= smooth_q;
					res_cv_q     <= cv_q;
					if (smooth_q < low_limit_q) begin
						res_band_q <= gfr_pkg::BAND_BELOW;
					end else if (smooth_q > high_limit_q) begin
						res_band_q <= gfr_pkg::BAND_ABOVE;
					end else begin
						res_band_q <= gfr_pkg::BAND_WITHIN;
					end
				end
			end
			default: ;
		endcase
	end

	// ports
	assign smp.ready                   = (state_q == ST_IDLE);
	assign cfg.ready                   = 1'b1;
	assign res.valid                   = res_valid_q;
	assign res.period_q8               = res_period_q;
	assign res.frequency_mhz           = res_freq_q;
	assign res.rms_centivolts          = res_cv_q;
	assign res.band_status             = res_band_q;
	assign res.drive_clockwise         = (res_band_q == gfr_pkg::BAND_BELOW);
	assign res.drive_counter_clockwise = (res_band_q == gfr_pkg::BAND_ABOVE);

`ifndef SYNTHESIS
	// an accepted sample beat starts the filter step
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(smp.valid && smp.ready) |=> (state_q == ST_BLEND))
		else $error("sample beat did not start the filter step");

	// a crossing always has at least one counted sample
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FRAC_W) |-> (count_q != '0))
		else $error("crossing with empty sample count");

	// leaving the emit state presents a result beat
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free) |=> res.valid)
		else $error("result beat missing after emit");
`endif

endmodule

[rtl/gfr_mul.sv]
// gfr_mul: shared signed multiplier with a registered product
// depends on gfr_pkg
module gfr_mul (
	input  logic                                clk,
	input  logic signed [gfr_pkg::MUL_A_W-1:0]  a,
	input  logic signed [gfr_pkg::MUL_B_W-1:0]  b,
	output logic signed [gfr_pkg::MUL_P_W-1:0]  prod
);

	logic signed [gfr_pkg::MUL_P_W-1:0] prod_q;

	// one product per cycle
	always_ff @(posedge clk) begin
		prod_q <= gfr_pkg::MUL_P_W'(a) * gfr_pkg::MUL_P_W'(b);
	end

	assign prod = prod_q;

endmodule

[rtl/gfr_div.sv]
// gfr_div: restoring divider, one quotient bit per cycle
// depends on gfr_pkg; numerator comes left-aligned, steps gives its bit count
module gfr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gfr_pkg::div_req_t             req,
	output logic                          done,
	output logic [gfr_pkg::DIV_W-1:0]     quo
);

	logic [gfr_pkg::DIV_W-1:0]  num_q;
	logic [gfr_pkg::DIV_W-1:0]  quo_q;
	logic [gfr_pkg::DEN_W-1:0]  rem_q;
	logic [gfr_pkg::DEN_W-1:0]  den_q;
	logic [gfr_pkg::STEP_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [gfr_pkg::DEN_W:0]    shifted;
	logic [gfr_pkg::DEN_W:0]    trial;

	// trial subtraction of the next bit
	always_comb begin
		shifted = {rem_q, num_q[gfr_pkg::DIV_W-1]};
		trial   = shifted - {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == gfr_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[gfr_pkg::DIV_W-2:0], 1'b0};
			if (!trial[gfr_pkg::DEN_W]) begin
				rem_q <= trial[gfr_pkg::DEN_W-1:0];
				quo_q <= {quo_q[gfr_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[gfr_pkg::DEN_W-1:0];
				quo_q <= {quo_q[gfr_pkg::DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[rtl/gfr_isqrt.sv]
// gfr_isqrt: integer square root, one result bit per cycle
// depends on gfr_pkg
module gfr_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [gfr_pkg::DIV_W-1:0]     val,
	output logic                          done,
	output logic [gfr_pkg::ROOT_W-1:0]    root
);

	localparam int CNT_W = $clog2(gfr_pkg::ROOT_W + 1);

	logic [gfr_pkg::DIV_W-1:0] v_q;
	logic [gfr_pkg::DIV_W:0]   r_q;
	logic [gfr_pkg::DIV_W-1:0] b_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [gfr_pkg::DIV_W:0]   t;

	assign t = r_q + {1'b0, b_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(gfr_pkg::ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// digit-by-digit root
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= val;
			r_q <= '0;
			b_q <= {2'b01, {(gfr_pkg::DIV_W-2){1'b0}}};
		end else if (busy_q) begin
			b_q <= {2'b00, b_q[gfr_pkg::DIV_W-1:2]};
			if ({1'b0, v_q} >= t) begin
				v_q <= v_q - t[gfr_pkg::DIV_W-1:0];
				r_q <= {1'b0, r_q[gfr_pkg::DIV_W:1]} + {1'b0, b_q};
			end else begin
				r_q <= {1'b0, r_q[gfr_pkg::DIV_W:1]};
			end
		end
	end

	assign done = done_q;
	assign root = r_q[gfr_pkg::ROOT_W-1:0];

endmodule
